// ===== design/tpdi_pkg.sv =====
// ----------------------------------------------------------------------------
// tpdi_pkg
// shared types and constants of the tracker packet deframer and frame index
// ----------------------------------------------------------------------------
package tpdi_pkg;

    localparam int MAX_FRAMES_DEF = 1024;

    // header layout
    localparam logic [7:0] MARK_SHORT    = 8'h78;
    localparam logic [7:0] MARK_LONG     = 8'h79;
    localparam int         HDR_LEN       = 5;
    localparam int         LONG_EXTRA    = 6;
    localparam int         ADMIT_MARGIN  = 10;

    // field widths of the result request
    localparam int OFS_W     = 32;
    localparam int SIZE_W    = 17;
    localparam int TYPE_W    = 8;
    localparam int IDX_OUT_W = 10;
    localparam int CNT_OUT_W = 11;

    // request codes
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_LOOKUP  = 1'b1;
    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic [OFS_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
        logic [TYPE_W-1:0] ftype;
    } frame_entry_t;

    typedef struct packed {
        logic done;
        logic found;
    } srch_stat_t;

endpackage

// ===== design/tracker_packet_deframer_index.sv =====
// ----------------------------------------------------------------------------
// tracker_packet_deframer_index
// packet deframer for a tracker byte stream with a searchable frame table
// ----------------------------------------------------------------------------
// requests enter on the s_ channel: s_tuser selects a stream byte or a
// lookup, s_tdata carries the byte and the query offset. results leave on
// the m_ channel through one output register: m_tuser gives the kind,
// m_tdata the frame fields and table status. stream_length is written on
// the cfg_ channel, which is always ready; the user must write it only
// while the block is idle, and the block itself does not enforce this.
// stream bytes are taken back to back while s_tready is high; a frame
// result is in the output register in the cycle after its fifth header
// byte is taken. a lookup runs a binary search on the frame table memory,
// each probe a read state then a compare state.
// s_tready is low while a lookup runs and while a held result cannot be
// taken, so a stalled receiver stalls the input side once the output
// register is full. reset clears the parser, the frame count and the
// halt and overflow flags; no clearing pass, table entries are only read
// below the frame count.
// ----------------------------------------------------------------------------
module tracker_packet_deframer_index #(
    parameter int MAX_FRAMES = tpdi_pkg::MAX_FRAMES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte, query_offset
    input  logic [0:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // frame_offset, frame_size, frame_type, frame_index,
                                   // found, frame_count, table_full
    output logic [0:0]  m_tuser,   // result_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import tpdi_pkg::*;

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } ctl_state_t;

    typedef enum logic [5:0] {
        PH_H0   = 6'b000001,
        PH_H1   = 6'b000010,
        PH_H2   = 6'b000100,
        PH_H3   = 6'b001000,
        PH_H4   = 6'b010000,
        PH_SKIP = 6'b100000
    } phase_t;

    ctl_state_t        state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [31:0]       stream_len_reg;
    logic [31:0]       bytepos_reg, bytepos_next;
    logic [31:0]       hdr_reg, hdr_next;
    logic [SIZE_W-1:0] skip_reg, skip_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              halted_reg, halted_next;
    logic              ovf_reg, ovf_next;
    logic              m_valid_reg, m_valid_next;

    logic              out_kind_reg;
    frame_entry_t      out_entry_reg;
    logic [IDX_OUT_W-1:0] out_index_reg;
    logic              out_found_reg;
    logic [CNT_OUT_W-1:0] out_count_reg;
    logic              out_full_reg;

    logic              s_acc;
    logic              cmd;
    logic [7:0]        in_byte;
    logic [31:0]       in_query;
    logic [7:0]        h0, h1, h2, h3;
    logic              is_short, is_long;
    logic [SIZE_W-1:0] dec_size, dec_skip;
    frame_entry_t      dec_entry;
    logic [32:0]       pos_plus;
    logic              admit;
    logic              tbl_we;
    logic              load_frame;
    logic              srch_start;
    srch_stat_t        srch_stat;
    frame_entry_t      res_entry;
    logic [AW-1:0]     res_index;
    logic [31:0]       idx_wide_frame, idx_wide_res, cnt_wide;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_acc     = s_tvalid && s_tready;
    assign cmd       = s_tuser[0];
    assign in_byte   = s_tdata[7:0];
    assign in_query  = s_tdata[39:8];

    // header decode
    assign h0       = hdr_reg[31:24];
    assign h1       = hdr_reg[23:16];
    assign h2       = hdr_reg[15:8];
    assign h3       = hdr_reg[7:0];
    assign is_short = (h0 == MARK_SHORT) && (h1 == MARK_SHORT);
    assign is_long  = (h0 == MARK_LONG) && (h1 == MARK_LONG);
    assign dec_size = is_short ? (SIZE_W'(h2) + SIZE_W'(HDR_LEN))
                               : (SIZE_W'({h2, h3}) + SIZE_W'(LONG_EXTRA));
    assign dec_skip = dec_size - SIZE_W'(HDR_LEN);
    assign dec_entry.offset = bytepos_reg - 32'(HDR_LEN - 1);
    assign dec_entry.size   = dec_size;
    assign dec_entry.ftype  = is_short ? h3 : in_byte;

    // header admission window
    assign pos_plus = {1'b0, bytepos_reg} + 33'(HDR_LEN);
    assign admit    = (stream_len_reg < 32'(ADMIT_MARGIN))
                    ? (pos_plus <= {1'b0, stream_len_reg})
                    : (bytepos_reg < (stream_len_reg - 32'(ADMIT_MARGIN)));

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        bytepos_next = bytepos_reg;
        hdr_next     = hdr_reg;
        skip_next    = skip_reg;
        count_next   = count_reg;
        halted_next  = halted_reg;
        ovf_next     = ovf_reg;
        tbl_we       = 1'b0;
        load_frame   = 1'b0;
        srch_start   = 1'b0;
        if (s_acc && cmd == CMD_LOOKUP) begin
            srch_start = 1'b1;
            state_next = ST_SEARCH;
        end else if (s_acc && !halted_reg) begin
            if (bytepos_reg != '1) begin
                bytepos_next = bytepos_reg + 32'd1;
            end
            case (phase_reg)
                PH_SKIP: begin
                    skip_next = skip_reg - SIZE_W'(1);
                    if (skip_reg <= SIZE_W'(1)) begin
                        phase_next = PH_H0;
                    end
                end
                PH_H0: begin
                    if (!admit) begin
                        halted_next = 1'b1;
                    end else begin
                        hdr_next   = {hdr_reg[23:0], in_byte};
                        phase_next = PH_H1;
                    end
                end
                PH_H1: begin
                    hdr_next   = {hdr_reg[23:0], in_byte};
                    phase_next = PH_H2;
                end
                PH_H2: begin
                    hdr_next   = {hdr_reg[23:0], in_byte};
                    phase_next = PH_H3;
                end
                PH_H3: begin
                    hdr_next   = {hdr_reg[23:0], in_byte};
                    phase_next = PH_H4;
                end
                PH_H4: begin
                    hdr_next   = '0;
                    phase_next = PH_H0;
                    if (is_short || is_long) begin
                        skip_next = dec_skip;
                        if (dec_skip != '0) begin
                            phase_next = PH_SKIP;
                        end
                        if (count_reg >= CW'(MAX_FRAMES)) begin
                            ovf_next = 1'b1;
                        end else begin
                            tbl_we     = 1'b1;
                            load_frame = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end else begin
                        halted_next = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_H0;
                end
            endcase
        end
        if (state_reg == ST_SEARCH && srch_stat.done) begin
            state_next = ST_IDLE;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_frame || srch_stat.done) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_H0;
            stream_len_reg <= '0;
            bytepos_reg    <= '0;
            hdr_reg        <= '0;
            skip_reg       <= '0;
            count_reg      <= '0;
            halted_reg     <= 1'b0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            bytepos_reg <= bytepos_next;
            hdr_reg     <= hdr_next;
            skip_reg    <= skip_next;
            count_reg   <= count_next;
            halted_reg  <= halted_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                stream_len_reg <= cfg_data;
            end
        end
    end

    assign idx_wide_frame = 32'(count_reg);
    assign idx_wide_res   = 32'(res_index);
    assign cnt_wide       = 32'(count_reg);

    always_ff @(posedge aclk) begin
        if (load_frame) begin
            out_kind_reg  <= KIND_FRAME;
            out_entry_reg <= dec_entry;
            out_index_reg <= idx_wide_frame[IDX_OUT_W-1:0];
            out_found_reg <= 1'b0;
            out_count_reg <= cnt_wide[CNT_OUT_W-1:0] + CNT_OUT_W'(1);
            out_full_reg  <= ovf_reg;
        end else if (srch_stat.done) begin
            out_kind_reg  <= KIND_LOOKUP;
            out_entry_reg <= res_entry;
            out_index_reg <= idx_wide_res[IDX_OUT_W-1:0];
            out_found_reg <= srch_stat.found;
            out_count_reg <= cnt_wide[CNT_OUT_W-1:0];
            out_full_reg  <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_full_reg, out_count_reg, out_found_reg, out_index_reg,
                       out_entry_reg.ftype, out_entry_reg.size, out_entry_reg.offset};

    tpdi_index #(
        .MAX_FRAMES (MAX_FRAMES),
        .AW         (AW),
        .CW         (CW)
    ) u_index (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (tbl_we),
        .wr_addr    (count_reg[AW-1:0]),
        .wr_entry   (dec_entry),
        .srch_start (srch_start),
        .srch_query (in_query),
        .srch_count (count_reg),
        .srch_stat  (srch_stat),
        .res_entry  (res_entry),
        .res_index  (res_index)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_FRAMES))
        else $error("frame count beyond table depth");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> count_reg == CW'(MAX_FRAMES))
        else $error("overflow flagged with room in table");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    a_no_accept_search: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |-> !s_tready)
        else $error("request taken during lookup");

    a_single_load: assert property (@(posedge aclk) disable iff (!aresetn)
        !(load_frame && srch_stat.done))
        else $error("frame and lookup result in the same cycle");
`endif

endmodule

// ===== design/tpdi_index.sv =====
// ----------------------------------------------------------------------------
// tpdi_index
// frame table memory with an iterative binary search, each probe a read then a compare
// ----------------------------------------------------------------------------
module tpdi_index #(
    parameter int MAX_FRAMES = tpdi_pkg::MAX_FRAMES_DEF,
    parameter int AW         = $clog2(MAX_FRAMES),
    parameter int CW         = $clog2(MAX_FRAMES + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  tpdi_pkg::frame_entry_t wr_entry,
    input  logic                   srch_start,
    input  logic [31:0]            srch_query,
    input  logic [CW-1:0]          srch_count,
    output tpdi_pkg::srch_stat_t   srch_stat,
    output tpdi_pkg::frame_entry_t res_entry,
    output logic [AW-1:0]          res_index
);
    import tpdi_pkg::*;

    typedef enum logic [2:0] {
        IX_IDLE  = 3'b001,
        IX_PROBE = 3'b010,
        IX_CMP   = 3'b100
    } ix_state_t;

    ix_state_t    state_reg, state_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hx_reg, hx_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic [31:0]   query_reg, query_next;
    logic          rd_en;
    logic [CW:0]   mid_sum;
    logic [32:0]   entry_end;
    frame_entry_t  rd_data_reg;
    frame_entry_t  frame_mem [MAX_FRAMES];

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hx_reg} - (CW+1)'(1);
    assign entry_end = {1'b0, rd_data_reg.offset} + 33'(rd_data_reg.size);

    always_comb begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hx_next    = hx_reg;
        mid_next   = mid_reg;
        query_next = query_reg;
        rd_en      = 1'b0;
        srch_stat  = '0;
        case (state_reg)
            IX_IDLE: begin
                if (srch_start) begin
                    lo_next    = '0;
                    hx_next    = srch_count;
                    query_next = srch_query;
                    state_next = IX_PROBE;
                end
            end
            IX_PROBE: begin
                if (lo_reg >= hx_reg) begin
                    srch_stat.done = 1'b1;
                    state_next     = IX_IDLE;
                end else begin
                    mid_next   = mid_sum[AW:1];
                    rd_en      = 1'b1;
                    state_next = IX_CMP;
                end
            end
            IX_CMP: begin
                if ({1'b0, query_reg} < {1'b0, rd_data_reg.offset}) begin
                    hx_next    = CW'(mid_reg);
                    state_next = IX_PROBE;
                end else if ({1'b0, query_reg} >= entry_end) begin
                    lo_next    = CW'(mid_reg) + CW'(1);
                    state_next = IX_PROBE;
                end else begin
                    srch_stat.done  = 1'b1;
                    srch_stat.found = 1'b1;
                    state_next      = IX_IDLE;
                end
            end
            default: begin
                state_next = IX_IDLE;
            end
        endcase
    end

    assign res_entry = srch_stat.found ? rd_data_reg : '0;
    assign res_index = srch_stat.found ? mid_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IX_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        hx_reg    <= hx_next;
        mid_reg   <= mid_next;
        query_reg <= query_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            frame_mem[wr_addr] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= frame_mem[mid_next];
        end
    end

endmodule

// ===== sim/tracker_packet_deframer_index_tb.sv =====
// ----------------------------------------------------------------------------
// tracker_packet_deframer_index_tb
// self-checking bench for the tracker packet deframer and its frame index.
// stream bytes and lookups go in on the s_ channel with random gaps, results
// are taken on the m_ channel with random stalls. a predictor in the bench
// follows every request and each result is compared with the oldest one
// due. covers both header forms, size extremes, lookup hits, misses and
// boundaries, header admission against stream_length, a full frame table,
// and, chosen per run, table overflow or a halted parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tracker_packet_deframer_index_tb;

    import tpdi_pkg::*;

    localparam int TB_FRAMES      = MAX_FRAMES_DEF;
    localparam int RESULT_LATENCY = 40;

    typedef enum int {
        PH_MARK0, PH_MARK1, PH_LEN0, PH_LEN1, PH_LAST, PH_SKIP
    } parse_phase_e;

    typedef struct {
        logic                 kind;
        logic [OFS_W-1:0]     ofs;
        logic [SIZE_W-1:0]    size;
        logic [TYPE_W-1:0]    ftype;
        logic [IDX_OUT_W-1:0] idx;
        logic                 found;
        logic [CNT_OUT_W-1:0] count;
        logic                 full;
    } deframer_result_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;   // data_byte, query_offset
    logic [0:0]  s_tuser   = '0;   // command
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;          // frame_offset, frame_size, frame_type, frame_index,
                                   // found, frame_count, table_full
    logic [0:0]  m_tuser;          // result_kind
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    // predictor state
    logic [OFS_W-1:0]  idx_ofs  [TB_FRAMES];
    logic [SIZE_W-1:0] idx_size [TB_FRAMES];
    logic [TYPE_W-1:0] idx_type [TB_FRAMES];
    int                frames_stored = 0;
    logic [31:0]       byte_pos      = '0;
    parse_phase_e      phase         = PH_MARK0;
    logic [31:0]       hdr_shift     = '0;
    int                skip_left     = 0;
    bit                halted        = 1'b0;
    bit                overflowed    = 1'b0;
    logic [31:0]       stream_len    = '0;

    deframer_result_t due_results[$];

    int sent_items   = 0;
    int taken        = 0;
    int frames_seen  = 0;
    int lookups_seen = 0;
    int fail_count   = 0;
    int idle_pct     = 50;
    bit send_idle_on = 1'b0;
    bit recv_idle_on = 1'b0;

    tracker_packet_deframer_index #(
        .MAX_FRAMES(TB_FRAMES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #60ms;
        $display("FAILURE");
        $finish;
    end

    task automatic predict_deframe(input logic cmd, input logic [7:0] b, input logic [31:0] q);
        deframer_result_t r;
        int               lo;
        int               hi;
        int               mid;
        logic [63:0]      lim;
        logic [63:0]      start;
        logic [63:0]      stop;
        logic [31:0]      pos;
        logic [SIZE_W-1:0] size;
        logic [7:0]       ftype;
        logic [7:0]       h0, h1, h2, h3;
        r = '{default: '0};
        if (cmd == CMD_LOOKUP) begin
            r.kind  = KIND_LOOKUP;
            r.count = CNT_OUT_W'(frames_stored);
            r.full  = overflowed;
            lo = 0;
            hi = frames_stored - 1;
            while (lo <= hi) begin
                mid   = (lo + hi) / 2;
                start = {32'd0, idx_ofs[mid]};
                stop  = start + 64'(idx_size[mid]);
                if ({32'd0, q} < start) begin
                    hi = mid - 1;
                end else if ({32'd0, q} >= stop) begin
                    lo = mid + 1;
                end else begin
                    r.ofs   = idx_ofs[mid];
                    r.size  = idx_size[mid];
                    r.ftype = idx_type[mid];
                    r.idx   = IDX_OUT_W'(mid);
                    r.found = 1'b1;
                    lo      = hi + 1;
                end
            end
            due_results.push_back(r);
            return;
        end
        if (halted) return;
        pos = byte_pos;
        if (byte_pos != '1) byte_pos++;
        if (phase == PH_SKIP) begin
            if (skip_left > 0) skip_left--;
            if (skip_left == 0) phase = PH_MARK0;
            return;
        end
        if (phase == PH_MARK0) begin
            lim = {32'd0, stream_len} - 64'(ADMIT_MARGIN);
            if (!({32'd0, pos} < lim && {32'd0, pos} + 64'(HDR_LEN) <= {32'd0, stream_len})) begin
                halted = 1'b1;
                return;
            end
        end
        if (phase != PH_LAST) begin
            hdr_shift = {hdr_shift[23:0], b};
            phase     = parse_phase_e'(int'(phase) + 1);
            return;
        end
        {h0, h1, h2, h3} = hdr_shift;
        hdr_shift = '0;
        phase     = PH_MARK0;
        if (h0 == MARK_SHORT && h1 == MARK_SHORT) begin
            size  = SIZE_W'(h2) + SIZE_W'(HDR_LEN);
            ftype = h3;
        end else if (h0 == MARK_LONG && h1 == MARK_LONG) begin
            size  = SIZE_W'({h2, h3}) + SIZE_W'(LONG_EXTRA);
            ftype = b;
        end else begin
            halted = 1'b1;
            return;
        end
        skip_left = int'(size) - HDR_LEN;
        if (skip_left > 0) phase = PH_SKIP;
        if (frames_stored >= TB_FRAMES) begin
            overflowed = 1'b1;
            return;
        end
        idx_ofs[frames_stored]  = pos - 32'(HDR_LEN - 1);
        idx_size[frames_stored] = size;
        idx_type[frames_stored] = ftype;
        frames_stored++;
        r.kind  = KIND_FRAME;
        r.ofs   = idx_ofs[frames_stored-1];
        r.size  = size;
        r.ftype = ftype;
        r.idx   = IDX_OUT_W'(frames_stored - 1);
        r.count = CNT_OUT_W'(frames_stored);
        r.full  = overflowed;
        due_results.push_back(r);
    endtask

    task automatic send_req(input logic cmd, input logic [7:0] b, input logic [31:0] q);
        int gap;
        if (sent_items % 32 == 0) send_idle_on = ($urandom_range(0, 99) < idle_pct);
        gap = send_idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {q, b};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        sent_items++;
        predict_deframe(cmd, b, q);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req(CMD_BYTE, b, $urandom());
    endtask

    task automatic send_lookup(input logic [31:0] q);
        send_req(CMD_LOOKUP, 8'($urandom()), q);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (RESULT_LATENCY) @(posedge aclk);
    endtask

    task automatic write_length(input logic [31:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        stream_len  = value;
    endtask

    function automatic logic [31:0] pick_query();
        int k;
        if (frames_stored == 0 || $urandom_range(0, 4) == 0) return $urandom();
        k = $urandom_range(0, frames_stored - 1);
        case ($urandom_range(0, 3))
            0: begin
                return idx_ofs[k];
            end
            1: begin
                return idx_ofs[k] + 32'(idx_size[k]) - 32'd1;
            end
            2: begin
                return idx_ofs[k] + 32'(idx_size[k]);
            end
            default: begin
                return idx_ofs[k] + $urandom_range(0, int'(idx_size[k]) - 1);
            end
        endcase
    endfunction

    // whole packet: header then body, lookups mixed in at random
    task automatic send_frame(input bit long_form, input int len, input logic [7:0] ftype,
                              input int lookup_pct);
        logic [7:0] head [5];
        int         body;
        if (long_form) begin
            head = '{MARK_LONG, MARK_LONG, len[15:8], len[7:0], ftype};
            body = len + 1;
        end else begin
            head = '{MARK_SHORT, MARK_SHORT, len[7:0], ftype, 8'($urandom())};
            body = len;
        end
        for (int i = 0; i < HDR_LEN + body; i++) begin
            if ($urandom_range(0, 99) < lookup_pct) send_lookup(pick_query());
            send_byte(i < HDR_LEN ? head[i] : 8'($urandom()));
        end
    endtask

    task automatic send_random_frame(input int lookup_pct);
        int len;
        bit long_form;
        long_form = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 19))
            0, 1:    len = $urandom_range(16, 255);
            2:       len = long_form ? $urandom_range(256, 1023) : $urandom_range(16, 255);
            default: len = $urandom_range(0, 15);
        endcase
        send_frame(long_form, len, 8'($urandom()), lookup_pct);
    endtask

    task automatic lookup_all_bounds();
        int n;
        n = frames_stored;
        for (int k = 0; k < n; k++) begin
            send_lookup(idx_ofs[k]);
            send_lookup(idx_ofs[k] + 32'(idx_size[k]) - 32'd1);
        end
    endtask

    task automatic test_empty_table();
        send_lookup(32'd0);
        send_lookup(32'hFFFF_FFFF);
        wait_idle();
    endtask

    // stream shorter than the admission margin, header must fit whole
    task automatic test_short_stream();
        write_length(32'(HDR_LEN));
        send_frame(1'b0, 0, 8'hFF, 0);
        send_lookup(32'd0);
        send_lookup(32'd4);
        send_lookup(32'd5);
        wait_idle();
    endtask

    task automatic test_frame_extremes();
        write_length(32'hFFFF_FFFF);
        send_frame(1'b0, 255, 8'h00, 0);
        send_frame(1'b0, 0, 8'h5A, 0);
        send_frame(1'b1, 0, 8'h00, 0);
        send_frame(1'b1, 16'h0102, 8'hFF, 0);
        send_frame(1'b0, 1, 8'hA5, 0);
        lookup_all_bounds();
        send_lookup(byte_pos);
        send_lookup(32'hFFFF_FFFF);
        wait_idle();
    endtask

    // header at the last offset still below stream_length - margin
    task automatic test_admit_boundary();
        write_length(byte_pos + 32'(ADMIT_MARGIN + 1));
        send_frame(1'b0, 2, 8'($urandom()), 0);
        write_length(byte_pos + 32'd100_000 + $urandom_range(0, 32'h7000_0000));
    endtask

    task automatic test_random_traffic();
        int pcts [4] = '{50, 0, 80, 50};
        int stop;
        for (int p = 0; p < 4; p++) begin
            if (p == 1) write_length(32'hFFFF_FFFF);
            else write_length(byte_pos + 32'd100_000 + $urandom_range(0, 32'h7000_0000));
            idle_pct = pcts[p];
            stop = sent_items + 100;
            while (sent_items < stop) begin
                if ($urandom_range(0, 5) == 0) send_lookup(pick_query());
                else send_random_frame(12);
            end
        end
        idle_pct = 50;
        wait_idle();
    endtask

    task automatic test_largest_frame();
        logic [31:0] ofs;
        idle_pct = 10;
        ofs      = byte_pos;
        send_frame(1'b1, 16'hFFFF, 8'($urandom()), 0);
        idle_pct = 50;
        send_lookup(ofs);
        send_lookup(ofs + 32'd65540);
        send_lookup(ofs + 32'd65541);
        wait_idle();
    endtask

    task automatic test_table_fill();
        write_length(byte_pos + 32'd1_000_000 + $urandom_range(0, 32'h7000_0000));
        while (frames_stored < TB_FRAMES) begin
            send_frame(1'b0, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0,
                       8'($urandom()), 2);
        end
        repeat (8) send_lookup(pick_query());
        send_lookup(32'hFFFF_FFFF);
        wait_idle();
    endtask

    // frames beyond a full table are dropped but still skipped
    task automatic test_table_overflow();
        send_frame(1'b0, 0, 8'($urandom()), 0);
        send_frame(1'b0, 3, 8'($urandom()), 0);
        send_frame(1'b1, 2, 8'($urandom()), 0);
        repeat (6) send_lookup(pick_query());
        wait_idle();
    endtask

    // a well-formed frame after the halt would otherwise raise the overflow flag
    task automatic test_parser_halt();
        logic [7:0] b0;
        logic [7:0] b1;
        if ($urandom_range(0, 1) == 0) begin
            write_length(($urandom_range(0, 1) == 0) ? byte_pos + 32'(ADMIT_MARGIN) : 32'd0);
            send_frame(1'b0, 0, 8'($urandom()), 0);
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    b0 = MARK_SHORT;
                    b1 = MARK_LONG;
                end
                1: begin
                    b0 = MARK_LONG;
                    b1 = MARK_SHORT;
                end
                default: begin
                    b0 = 8'($urandom());
                    if (b0 == MARK_SHORT || b0 == MARK_LONG) b0 = 8'h00;
                    b1 = b0;
                end
            endcase
            send_byte(b0);
            send_byte(b1);
            repeat (3) send_byte(8'($urandom()));
        end
        send_frame(1'b0, 1, 8'($urandom()), 20);
        send_frame(1'b1, 0, 8'($urandom()), 20);
        repeat (4) send_lookup(pick_query());
        wait_idle();
    endtask

    task automatic test_zero_length_setting();
        write_length(32'd0);
        send_frame(1'b0, 0, 8'($urandom()), 0);
        send_lookup(pick_query());
        wait_idle();
    endtask

    function automatic bit results_match(input deframer_result_t a, input deframer_result_t b);
        return a.kind === b.kind && a.ofs === b.ofs && a.size === b.size &&
               a.ftype === b.ftype && a.idx === b.idx && a.found === b.found &&
               a.count === b.count && a.full === b.full;
    endfunction

    task automatic show_result(input string tag, input deframer_result_t r);
        $display("  %s kind=%0d ofs=%h size=%0d type=%h idx=%0d found=%0b count=%0d full=%0b",
                 tag, r.kind, r.ofs, r.size, r.ftype, r.idx, r.found, r.count, r.full);
    endtask

    initial begin : result_check
        deframer_result_t got;
        deframer_result_t want;
        int               stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (taken % 32 == 0) recv_idle_on = ($urandom_range(0, 99) < idle_pct);
            stall = recv_idle_on ? $urandom_range(0, 17) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
            got.kind  = m_tuser[0];
            got.ofs   = m_tdata[31:0];
            got.size  = m_tdata[48:32];
            got.ftype = m_tdata[56:49];
            got.idx   = m_tdata[66:57];
            got.found = m_tdata[67];
            got.count = m_tdata[78:68];
            got.full  = m_tdata[79];
            if (got.kind == KIND_FRAME) frames_seen++;
            else lookups_seen++;
            if (due_results.size() == 0) begin
                if (fail_count < 10) begin
                    $display("result with none due at %0t", $realtime);
                    show_result("actual  ", got);
                end
                fail_count++;
            end else begin
                want = due_results.pop_front();
                if (!results_match(want, got)) begin
                    if (fail_count < 10) begin
                        $display("result mismatch at %0t", $realtime);
                        show_result("expected", want);
                        show_result("actual  ", got);
                    end
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_table();
        test_short_stream();
        test_frame_extremes();
        test_admit_boundary();
        test_random_traffic();
        test_largest_frame();
        test_table_fill();
        if ($urandom_range(0, 2) == 0) test_table_overflow();
        else test_parser_halt();
        test_zero_length_setting();
        wait_idle();
        if (due_results.size() != 0) begin
            $display("%0d results never arrived", due_results.size());
            fail_count += due_results.size();
        end
        $display("sent %0d requests; checked %0d frame results and %0d lookup answers",
                 sent_items, frames_seen, lookups_seen);
        $display("frame table ended with %0d entries, overflow=%0b, parser halted=%0b",
                 frames_stored, overflowed, halted);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tpdi_pkg.sv
design/tpdi_index.sv
design/tracker_packet_deframer_index.sv
sim/tracker_packet_deframer_index_tb.sv
